[hw/rtl/hpm_pkg.sv]
package hpm_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned MagW   = 64;
  localparam int unsigned QuoW   = 32;
  localparam int unsigned SumW   = 66;

  localparam logic [2:0] REG_LINEAR_TOP  = 3'd0;
  localparam logic [2:0] REG_LINEAR_MID  = 3'd1;
  localparam logic [2:0] REG_OFFSET      = 3'd2;
  localparam logic [2:0] REG_PERSPECTIVE = 3'd3;
  localparam logic [2:0] REG_DEN_BIAS    = 3'd4;

  localparam logic [63:0] LINEAR_TOP_RST  = 64'h0001_0000_0000_0000;
  localparam logic [63:0] LINEAR_MID_RST  = 64'h0000_0000_0001_0000;
  localparam logic [31:0] DEN_BIAS_RST    = 32'h0001_0000;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // Sign and magnitude of the three projective sums.
  typedef struct packed {
    logic            neg_u;
    logic            neg_v;
    logic            neg_w;
    logic [MagW-1:0] mag_u;
    logic [MagW-1:0] mag_v;
    logic [MagW-1:0] mag_w;
  } hpm_sums_t;

  // One stage of the two division lanes sharing a divisor.
  typedef struct packed {
    logic [MagW-1:0] rem_u;
    logic [MagW-1:0] rem_v;
    logic [QuoW-1:0] low_u;
    logic [QuoW-1:0] low_v;
    logic [QuoW-1:0] quo_u;
    logic [QuoW-1:0] quo_v;
    logic [MagW-1:0] den;
    logic            neg_u;
    logic            neg_v;
    logic            big_u;
    logic            big_v;
    logic            zero_den;
  } hpm_div_t;

  // One restoring step: shift in a dividend bit, subtract when it fits.
  function automatic logic [MagW:0] div_step(input logic [MagW-1:0] rem,
                                             input logic            din,
                                             input logic [MagW-1:0] den);
    logic [MagW:0] t;
    logic          qb;
    t  = {rem, din};
    qb = (t >= {1'b0, den});
    if (qb) begin
      t = t - {1'b0, den};
    end
    return {qb, t[MagW-1:0]};
  endfunction

endpackage

[hw/rtl/hpm_mac.sv]
module hpm_mac
  import hpm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic signed [CoordW-1:0] x,
  input  logic signed [CoordW-1:0] y,
  input  logic [63:0]              lin_top,
  input  logic [63:0]              lin_mid,
  input  logic [63:0]              offs,
  input  logic [63:0]              persp,
  input  logic [31:0]              bias,
  output logic                     out_vld,
  output hpm_sums_t                sums
);

  logic               prod_vld_r;
  logic signed [63:0] pa_r, pb_r, pc_r, pd_r, pp_r, pq_r;
  logic signed [63:0] pa_nxt, pb_nxt, pc_nxt, pd_nxt, pp_nxt, pq_nxt;
  logic signed [31:0] tu_r, tv_r, w0_r;
  logic               sum_vld_r;
  hpm_sums_t          sums_r, sums_nxt;
  logic signed [SumW-1:0] su, sv, sw;
  logic signed [SumW-1:0] au, av, aw;

  always_comb begin
    pa_nxt = x * $signed(lin_top[63:32]);
    pb_nxt = y * $signed(lin_top[31:0]);
    pc_nxt = x * $signed(lin_mid[63:32]);
    pd_nxt = y * $signed(lin_mid[31:0]);
    pp_nxt = x * $signed(persp[63:32]);
    pq_nxt = y * $signed(persp[31:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      sum_vld_r  <= 1'b0;
    end else begin
      prod_vld_r <= in_vld;
      sum_vld_r  <= prod_vld_r;
    end
    pa_r <= pa_nxt;
    pb_r <= pb_nxt;
    pc_r <= pc_nxt;
    pd_r <= pd_nxt;
    pp_r <= pp_nxt;
    pq_r <= pq_nxt;
    tu_r <= $signed(offs[63:32]);
    tv_r <= $signed(offs[31:0]);
    w0_r <= $signed(bias);
    sums_r <= sums_nxt;
  end

  // The scaled offsets and bias are sign-extended like the products.
  always_comb begin
    su = SumW'(pa_r) + SumW'(pb_r) + SumW'($signed({tu_r, 16'b0}));
    sv = SumW'(pc_r) + SumW'(pd_r) + SumW'($signed({tv_r, 16'b0}));
    sw = SumW'(pp_r) + SumW'(pq_r) + SumW'($signed({w0_r, 30'b0}));
    au = su[SumW-1] ? -su : su;
    av = sv[SumW-1] ? -sv : sv;
    aw = sw[SumW-1] ? -sw : sw;
    sums_nxt.neg_u = su[SumW-1];
    sums_nxt.neg_v = sv[SumW-1];
    sums_nxt.neg_w = sw[SumW-1];
    sums_nxt.mag_u = au[MagW-1:0];
    sums_nxt.mag_v = av[MagW-1:0];
    sums_nxt.mag_w = aw[MagW-1:0];
  end

  assign out_vld = sum_vld_r;
  assign sums    = sums_r;

endmodule

[hw/rtl/hpm_divider.sv]
module hpm_divider
  import hpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  input  hpm_sums_t sums,
  output logic      out_vld,
  output hpm_div_t  res
);

  logic     vld_r [0:QuoW];
  hpm_div_t st_r  [0:QuoW];
  hpm_div_t setup_nxt;

  // Quotient at or above 2^32 exactly when the dividend's upper part
  // reaches the divisor; otherwise that upper part is the first remainder.
  always_comb begin
    setup_nxt.den      = sums.mag_w;
    setup_nxt.zero_den = (sums.mag_w == '0);
    setup_nxt.big_u    = ({2'b0, sums.mag_u[MagW-1:2]} >= sums.mag_w);
    setup_nxt.big_v    = ({2'b0, sums.mag_v[MagW-1:2]} >= sums.mag_w);
    setup_nxt.rem_u    = {2'b0, sums.mag_u[MagW-1:2]};
    setup_nxt.rem_v    = {2'b0, sums.mag_v[MagW-1:2]};
    setup_nxt.low_u    = {sums.mag_u[1:0], 30'b0};
    setup_nxt.low_v    = {sums.mag_v[1:0], 30'b0};
    setup_nxt.quo_u    = '0;
    setup_nxt.quo_v    = '0;
    setup_nxt.neg_u    = setup_nxt.zero_den ? sums.neg_u : (sums.neg_u ^ sums.neg_w);
    setup_nxt.neg_v    = setup_nxt.zero_den ? sums.neg_v : (sums.neg_v ^ sums.neg_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    st_r[0] <= setup_nxt;
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    hpm_div_t      nxt;
    logic [MagW:0] ru, rv;
    always_comb begin
      ru        = div_step(st_r[k].rem_u, st_r[k].low_u[QuoW-1], st_r[k].den);
      rv        = div_step(st_r[k].rem_v, st_r[k].low_v[QuoW-1], st_r[k].den);
      nxt       = st_r[k];
      nxt.rem_u = ru[MagW-1:0];
      nxt.rem_v = rv[MagW-1:0];
      nxt.low_u = {st_r[k].low_u[QuoW-2:0], 1'b0};
      nxt.low_v = {st_r[k].low_v[QuoW-2:0], 1'b0};
      nxt.quo_u = {st_r[k].quo_u[QuoW-2:0], ru[MagW]};
      nxt.quo_v = {st_r[k].quo_v[QuoW-2:0], rv[MagW]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      st_r[k+1] <= nxt;
    end
  end

  assign out_vld = vld_r[QuoW];
  assign res     = st_r[QuoW];

endmodule

[hw/rtl/homography_point_map.sv]
// Each word goes through the input, product, sum, divider and output registers in order.
// Throughput: one word per cycle; busy stays low and start may be high in every cycle.
// The depth is set by the 32-step restoring divider, one quotient bit per stage.
// Synchronous active-low reset clears the valid bits and loads the identity matrix.
// The receiver cannot stall: out_valid is a one-cycle strobe per result.
module homography_point_map
  import hpm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] in_coord_x,
  input  logic signed [CoordW-1:0] in_coord_y,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [63:0]              cfg_data,
  output logic                     out_valid,
  output logic signed [CoordW-1:0] out_mapped_u,
  output logic signed [CoordW-1:0] out_mapped_v,
  output logic                     out_zero_denominator,
  output logic                     out_clipped
);

  logic [63:0] lin_top_r, lin_mid_r, offs_r, persp_r;
  logic [31:0] bias_r;

  logic               in_vld_r;
  logic signed [31:0] x_r, y_r;

  logic      mac_vld, div_vld;
  hpm_sums_t sums;
  hpm_div_t  res;

  logic        out_vld_r;
  logic [31:0] u_r, v_r, u_nxt, v_nxt;
  logic        zd_r, clip_r, clip_u, clip_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_top_r <= LINEAR_TOP_RST;
      lin_mid_r <= LINEAR_MID_RST;
      offs_r    <= '0;
      persp_r   <= '0;
      bias_r    <= DEN_BIAS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINEAR_TOP:  lin_top_r <= cfg_data;
        REG_LINEAR_MID:  lin_mid_r <= cfg_data;
        REG_OFFSET:      offs_r    <= cfg_data;
        REG_PERSPECTIVE: persp_r   <= cfg_data;
        REG_DEN_BIAS:    bias_r    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
    x_r <= in_coord_x;
    y_r <= in_coord_y;
  end

  assign busy = 1'b0;

  hpm_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld_r),
    .x       (x_r),
    .y       (y_r),
    .lin_top (lin_top_r),
    .lin_mid (lin_mid_r),
    .offs    (offs_r),
    .persp   (persp_r),
    .bias    (bias_r),
    .out_vld (mac_vld),
    .sums    (sums)
  );

  hpm_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (mac_vld),
    .sums    (sums),
    .out_vld (div_vld),
    .res     (res)
  );

  // A zero divisor gives saturation by numerator sign with no clip.
  always_comb begin
    clip_u = 1'b0;
    clip_v = 1'b0;
    if (res.zero_den) begin
      u_nxt = res.neg_u ? SAT_NEG : SAT_POS;
      v_nxt = res.neg_v ? SAT_NEG : SAT_POS;
    end else begin
      if (!res.neg_u) begin
        clip_u = res.big_u || (res.quo_u > SAT_POS);
        u_nxt  = clip_u ? SAT_POS : res.quo_u;
      end else begin
        clip_u = res.big_u || (res.quo_u > SAT_NEG);
        u_nxt  = clip_u ? SAT_NEG : (~res.quo_u + 32'd1);
      end
      if (!res.neg_v) begin
        clip_v = res.big_v || (res.quo_v > SAT_POS);
        v_nxt  = clip_v ? SAT_POS : res.quo_v;
      end else begin
        clip_v = res.big_v || (res.quo_v > SAT_NEG);
        v_nxt  = clip_v ? SAT_NEG : (~res.quo_v + 32'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= div_vld;
    end
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    zd_r   <= res.zero_den;
    clip_r <= clip_u | clip_v;
  end

  assign out_valid            = out_vld_r;
  assign out_mapped_u         = $signed(u_r);
  assign out_mapped_v         = $signed(v_r);
  assign out_zero_denominator = zd_r;
  assign out_clipped          = clip_r;

endmodule

[hw/rtl/hpm_checker.sv]
module hpm_checker
  import hpm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [CoordW-1:0] out_mapped_u,
  input logic [CoordW-1:0] out_mapped_v,
  input logic              out_zero_denominator,
  input logic              out_clipped
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##37 out_valid)
    else $error("accepted word produced no result after 37 cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, 37))
    else $error("result without an accepted word");

  a_zero_den_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_denominator |-> !out_clipped
      && (out_mapped_u == SAT_POS || out_mapped_u == SAT_NEG)
      && (out_mapped_v == SAT_POS || out_mapped_v == SAT_NEG))
    else $error("zero denominator result not saturated");

  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      out_mapped_u == SAT_POS || out_mapped_u == SAT_NEG
      || out_mapped_v == SAT_POS || out_mapped_v == SAT_NEG)
    else $error("clipped result without a saturated value");

endmodule

bind homography_point_map hpm_checker u_hpm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_mapped_u         (out_mapped_u),
  .out_mapped_v         (out_mapped_v),
  .out_zero_denominator (out_zero_denominator),
  .out_clipped          (out_clipped)
);
